FILE: hw/rtl/cht_pkg.sv
// Shared types, field widths and codes of the chained hash table.
package cht_pkg;

    localparam int CMD_W = 2;
    localparam int KEY_W = 31;
    localparam int VAL_W = 32;
    localparam int STS_W = 3;

    localparam int BUCKETS_DEF = 32;
    localparam int SLOTS_DEF   = 8;

    localparam logic [CMD_W-1:0] OP_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] OP_FIND   = 2'd1;
    localparam logic [CMD_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STS_W-1:0] ST_ADDED    = 3'd0;
    localparam logic [STS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STS_W-1:0] ST_FOUND    = 3'd2;
    localparam logic [STS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STS_W-1:0] ST_REMOVED  = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] value;
    } cht_req_t;

    typedef struct packed {
        logic [STS_W-1:0]        status;
        logic signed [VAL_W-1:0] found_value;
        logic                    last;
    } cht_rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             clr_step;
        logic             in_load;
        logic             hash_start;
        logic             fill_re;
        logic             fill_load;
        logic             add_write;
        logic             rd_first;
        logic             scan_next;
        logic             pend_load;
        logic             emit_pend;
        logic             rm_mark;
        logic             sh_read;
        logic             sh_write;
        logic             fill_dec;
        logic             fin_set;
        logic [STS_W-1:0] fin_status;
        logic             emit_final;
    } cht_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic             clr_last;
        logic             hash_done;
        logic [CMD_W-1:0] op;
        logic             fill_full;
        logic             fill_zero;
        logic             key_match;
        logic             kv_match;
        logic             scan_last;
        logic             sh_more;
        logic             pend_valid;
        logic             can_emit;
    } cht_sts_t;

endpackage

FILE: hw/rtl/cht_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/cht_mod.sv
// Bucket index unit: key modulo the bucket count.
module cht_mod #(
    parameter int BUCKETS = cht_pkg::BUCKETS_DEF,
    parameter int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [cht_pkg::KEY_W-1:0] key,
    output logic                     done,
    output logic [BKT_W-1:0]         bucket
);
    import cht_pkg::*;

    localparam bit IS_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

    generate
        if (IS_POW2)
        begin : g_mask
            logic             done_reg;
            logic [BKT_W-1:0] bkt_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    bkt_reg <= BKT_W'(key & KEY_W'(BUCKETS - 1));
                end
            end

            assign done   = done_reg;
            assign bucket = bkt_reg;
        end
        else
        begin : g_serial
            // Two key bits per cycle, most significant first: r = (2r + bit) mod BUCKETS.
            localparam int ITER  = (KEY_W + 1) / 2;
            localparam int BITS  = 2 * ITER;
            localparam int CNT_W = $clog2(ITER + 1);
            localparam logic [BKT_W:0] MODULUS = (BKT_W + 1)'(BUCKETS);

            logic             busy_reg;
            logic             done_reg;
            logic [CNT_W-1:0] cnt_reg;
            logic [BITS-1:0]  bits_reg;
            logic [BKT_W-1:0] rem_reg;
            logic [BKT_W-1:0] rem_next;

            always_comb
            begin
                logic [BKT_W:0]   t;
                logic [BKT_W-1:0] r;
                r = rem_reg;
                for (int k = 0; k < 2; k++)
                begin
                    t = {r, bits_reg[BITS-1-k]};
                    if (t >= MODULUS)
                    begin
                        t = t - MODULUS;
                    end
                    r = t[BKT_W-1:0];
                end
                rem_next = r;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b0;
                    cnt_reg  <= '0;
                end
                else
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        busy_reg <= 1'b1;
                        cnt_reg  <= CNT_W'(ITER);
                    end
                    else if (busy_reg)
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                        if (cnt_reg == CNT_W'(1))
                        begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    bits_reg <= {{(BITS - KEY_W){1'b0}}, key};
                    rem_reg  <= '0;
                end
                else if (busy_reg)
                begin
                    bits_reg <= {bits_reg[BITS-3:0], 2'b00};
                    rem_reg  <= rem_next;
                end
            end

            assign done   = done_reg;
            assign bucket = rem_reg;
        end
    endgenerate

endmodule

FILE: hw/rtl/cht_datapath.sv
// Datapath: input and output registers, bucket index, slot and fill memories, scan indexes.
module cht_datapath #(
    parameter int BUCKETS          = cht_pkg::BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = cht_pkg::SLOTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cht_pkg::cht_req_t req,
    input  logic              rsp_ready,
    output logic              rsp_valid,
    output cht_pkg::cht_rsp_t rsp,
    input  cht_pkg::cht_ctl_t ctl,
    output cht_pkg::cht_sts_t sts
);
    import cht_pkg::*;

    localparam int TOTAL  = BUCKETS * SLOTS_PER_BUCKET;
    localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int ADDR_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int IDX_W  = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int FILL_W = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int WORD_W = KEY_W + VAL_W;

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [BKT_W-1:0] b,
                                                     input logic [FILL_W-1:0] i);
        return ADDR_W'(ADDR_W'(b) * ADDR_W'(SLOTS_PER_BUCKET)) + ADDR_W'(i);
    endfunction

    cht_req_t         in_reg;
    logic [BKT_W-1:0] clr_cnt_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] j_reg;
    logic             pend_valid_reg;
    logic [VAL_W-1:0] pend_value_reg;
    logic [STS_W-1:0] fin_status_reg;
    logic             out_valid_reg;
    cht_rsp_t         out_reg;

    logic             hash_done;
    logic [BKT_W-1:0] bucket;

    logic              slot_we;
    logic [ADDR_W-1:0] slot_waddr;
    logic [WORD_W-1:0] slot_wdata;
    logic              slot_re;
    logic [ADDR_W-1:0] slot_raddr;
    logic [WORD_W-1:0] slot_rdata;

    logic              fill_we;
    logic [BKT_W-1:0]  fill_waddr;
    logic [FILL_W-1:0] fill_wdata;
    logic [FILL_W-1:0] fill_rdata;

    logic             can_emit;
    logic [IDX_W-1:0] idx_inc;
    logic [IDX_W-1:0] j_inc;

    cht_mod #(
        .BUCKETS (BUCKETS),
        .BKT_W   (BKT_W)
    ) u_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ctl.hash_start),
        .key    (req.key),
        .done   (hash_done),
        .bucket (bucket)
    );

    cht_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TOTAL),
        .AW    (ADDR_W)
    ) u_slots (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    cht_ram #(
        .WIDTH (FILL_W),
        .DEPTH (BUCKETS),
        .AW    (BKT_W)
    ) u_fill (
        .clk   (clk),
        .we    (fill_we),
        .waddr (fill_waddr),
        .wdata (fill_wdata),
        .re    (ctl.fill_re),
        .raddr (bucket),
        .rdata (fill_rdata)
    );

    assign idx_inc  = idx_reg + 1'b1;
    assign j_inc    = j_reg + 1'b1;
    assign can_emit = !out_valid_reg || rsp_ready;

    always_comb
    begin
        slot_we    = ctl.add_write || ctl.sh_write;
        slot_waddr = ctl.add_write ? slot_addr(bucket, fill_rdata)
                                   : slot_addr(bucket, FILL_W'(j_reg));
        slot_wdata = ctl.add_write ? {in_reg.key, in_reg.value} : slot_rdata;

        slot_re = ctl.rd_first || ctl.scan_next || ctl.sh_read;
        priority if (ctl.sh_read)
        begin
            slot_raddr = slot_addr(bucket, FILL_W'(j_inc));
        end
        else if (ctl.scan_next)
        begin
            slot_raddr = slot_addr(bucket, FILL_W'(idx_inc));
        end
        else
        begin
            slot_raddr = slot_addr(bucket, '0);
        end

        fill_we = ctl.clr_step || ctl.add_write || ctl.fill_dec;
        priority if (ctl.clr_step)
        begin
            fill_waddr = clr_cnt_reg;
            fill_wdata = '0;
        end
        else if (ctl.add_write)
        begin
            fill_waddr = bucket;
            fill_wdata = fill_rdata + 1'b1;
        end
        else
        begin
            fill_waddr = bucket;
            fill_wdata = fill_reg - 1'b1;
        end
    end

    always_comb
    begin
        sts.clr_last   = clr_cnt_reg == BKT_W'(BUCKETS - 1);
        sts.hash_done  = hash_done;
        sts.op         = in_reg.cmd;
        sts.fill_full  = fill_rdata >= FILL_W'(SLOTS_PER_BUCKET);
        sts.fill_zero  = fill_rdata == '0;
        sts.key_match  = slot_rdata[VAL_W +: KEY_W] == in_reg.key;
        sts.kv_match   = slot_rdata == {in_reg.key, in_reg.value};
        sts.scan_last  = (FILL_W'(idx_reg) + 1'b1) == fill_reg;
        sts.sh_more    = (FILL_W'(j_reg) + 1'b1) < fill_reg;
        sts.pend_valid = pend_valid_reg;
        sts.can_emit   = can_emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (ctl.in_load)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (ctl.pend_load)
            begin
                pend_valid_reg <= 1'b1;
            end
            if (ctl.emit_pend || ctl.emit_final)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.in_load)
        begin
            in_reg <= req;
        end
        if (ctl.fill_load)
        begin
            fill_reg <= fill_rdata;
        end
        if (ctl.rd_first)
        begin
            idx_reg <= '0;
        end
        else if (ctl.scan_next)
        begin
            idx_reg <= idx_inc;
        end
        if (ctl.rm_mark)
        begin
            j_reg <= idx_reg;
        end
        else if (ctl.sh_write)
        begin
            j_reg <= j_inc;
        end
        if (ctl.pend_load)
        begin
            pend_value_reg <= slot_rdata[VAL_W-1:0];
        end
        if (ctl.fin_set)
        begin
            fin_status_reg <= ctl.fin_status;
        end
        // An earlier match goes out once a later one shows it is not the last and the output register has room.
        if (ctl.emit_pend)
        begin
            out_reg.status      <= ST_FOUND;
            out_reg.found_value <= pend_value_reg;
            out_reg.last        <= 1'b0;
        end
        else if (ctl.emit_final)
        begin
            out_reg.status      <= fin_status_reg;
            out_reg.found_value <= (fin_status_reg == ST_FOUND) ? pend_value_reg : '0;
            out_reg.last        <= 1'b1;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.emit_pend || ctl.emit_final) |-> (!out_valid_reg || rsp_ready))
        else $error("result written while the output register is still occupied");

    a_emit_single: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.emit_pend && ctl.emit_final))
        else $error("two results written in one cycle");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_we |-> (fill_wdata <= FILL_W'(SLOTS_PER_BUCKET)))
        else $error("bucket fill written beyond the slot count");

    a_shift_order: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.sh_write |-> $past(ctl.sh_read))
        else $error("slot moved down without reading it first");

endmodule

FILE: hw/rtl/cht_ctrl.sv
// Controller state machine: sequences the clearing pass, hashing, memory reads, scans, moves and results.
module cht_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  cht_pkg::cht_sts_t sts,
    output cht_pkg::cht_ctl_t ctl
);
    import cht_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_HASH  = 8'b0000_0100,
        S_FILL  = 8'b0000_1000,
        S_SCAN  = 8'b0001_0000,
        S_SH_RD = 8'b0010_0000,
        S_SH_WR = 8'b0100_0000,
        S_FINAL = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   need_emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A second match of a find must first push the earlier one out.
    assign need_emit = sts.key_match && sts.pend_valid;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl.in_load    = 1'b1;
                    ctl.hash_start = 1'b1;
                    state_next     = S_HASH;
                end
            end
            S_HASH:
            begin
                if (sts.hash_done)
                begin
                    ctl.fill_re = 1'b1;
                    state_next  = S_FILL;
                end
            end
            S_FILL:
            begin
                ctl.fill_load = 1'b1;
                priority if (sts.op == OP_ADD)
                begin
                    ctl.fin_set = 1'b1;
                    if (sts.fill_full)
                    begin
                        ctl.fin_status = ST_FULL;
                    end
                    else
                    begin
                        ctl.add_write  = 1'b1;
                        ctl.fin_status = ST_ADDED;
                    end
                    state_next = S_FINAL;
                end
                else if (sts.op == OP_FIND || sts.op == OP_REMOVE)
                begin
                    if (sts.fill_zero)
                    begin
                        ctl.fin_set    = 1'b1;
                        ctl.fin_status = ST_NOTFOUND;
                        state_next     = S_FINAL;
                    end
                    else
                    begin
                        ctl.rd_first = 1'b1;
                        state_next   = S_SCAN;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (sts.op == OP_FIND)
                begin
                    if (!(need_emit && !sts.can_emit))
                    begin
                        ctl.pend_load = sts.key_match;
                        ctl.emit_pend = need_emit;
                        if (sts.scan_last)
                        begin
                            ctl.fin_set    = 1'b1;
                            ctl.fin_status = (sts.key_match || sts.pend_valid)
                                           ? ST_FOUND : ST_NOTFOUND;
                            state_next     = S_FINAL;
                        end
                        else
                        begin
                            ctl.scan_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    priority if (sts.kv_match)
                    begin
                        ctl.rm_mark = 1'b1;
                        state_next  = S_SH_RD;
                    end
                    else if (sts.scan_last)
                    begin
                        ctl.fin_set    = 1'b1;
                        ctl.fin_status = ST_NOTFOUND;
                        state_next     = S_FINAL;
                    end
                    else
                    begin
                        ctl.scan_next = 1'b1;
                    end
                end
            end
            S_SH_RD:
            begin
                if (sts.sh_more)
                begin
                    ctl.sh_read = 1'b1;
                    state_next  = S_SH_WR;
                end
                else
                begin
                    ctl.fill_dec   = 1'b1;
                    ctl.fin_set    = 1'b1;
                    ctl.fin_status = ST_REMOVED;
                    state_next     = S_FINAL;
                end
            end
            S_SH_WR:
            begin
                ctl.sh_write = 1'b1;
                state_next   = S_SH_RD;
            end
            S_FINAL:
            begin
                if (sts.can_emit)
                begin
                    ctl.emit_final = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/chained_hash_table_core.sv
// Top level of the chained hash table: controller and datapath.
//
//   channel | signals                 | beat
//   --------+-------------------------+---------------------------------------
//   req     | req_valid, req_ready    | one command: cmd, key, value
//   rsp     | rsp_valid, rsp_ready    | one result: status, found_value, last
//
// A remove that hits moves every later entry of its bucket down one slot, reading and then
// writing each (the slot memory has one port of each kind); a remove that misses scans
// like a find. The bucket index takes two key bits a cycle unless BUCKETS is a power of two.
// After reset a clearing pass zeroes the bucket fill memory; no command is taken
// meanwhile. A stalled rsp holds one result in the output register; the scan waits
// only when a further result is ready.
module chained_hash_table_core #(
    parameter int BUCKETS          = cht_pkg::BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = cht_pkg::SLOTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  cht_pkg::cht_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output cht_pkg::cht_rsp_t rsp
);
    import cht_pkg::*;

    cht_ctl_t ctl;
    cht_sts_t sts;

    cht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    cht_datapath #(
        .BUCKETS          (BUCKETS),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .ctl       (ctl),
        .sts       (sts)
    );

endmodule
